FILE: rtl/bqf_pkg.sv
// shared types, constants and the sequencer program of the biquad filter
package bqf_pkg;

   // accumulator format
   localparam int ACC_BITS  = 48;
   localparam int ACC_GUARD = 8;

   // configuration port
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int REG_IDX_BITS  = 3;

   // sequencer program counter
   localparam int STEP_BITS = 3;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_FF_GAIN_0 = 3'd0,
      REG_FF_GAIN_1 = 3'd1,
      REG_FF_GAIN_2 = 3'd2,
      REG_FB_GAIN_1 = 3'd3,
      REG_FB_GAIN_2 = 3'd4,
      REG_BYPASS    = 3'd5
   } reg_idx_type;

   typedef enum logic [2:0] {
      COEF_B0,
      COEF_B1,
      COEF_B2,
      COEF_A1,
      COEF_A2
   } coef_sel_type;

   typedef enum logic [2:0] {
      OP_NONE,   // no accumulator action
      OP_CLEAR,  // clear the clip flag at the start of an item
      OP_LOAD,   // acc = sat(term + source)
      OP_SUB,    // acc = sat(acc - term)
      OP_ROUND,  // y = sat(round(acc >> guard))
      OP_PASS    // y = x, no clip
   } alu_op_type;

   typedef enum logic [1:0] {
      SRC_D1,
      SRC_D2,
      SRC_ZERO
   } src_sel_type;

   // one control word of the microprogram
   typedef struct packed {
      logic                 mul_en;
      logic                 mul_y;
      coef_sel_type         coef;
      alu_op_type           op;
      src_sel_type          src;
      logic                 wr_d1;
      logic                 wr_d2;
      logic                 br_bypass;
      logic                 last;
      logic [STEP_BITS-1:0] target;
   } ctrl_word_type;

   // step addresses
   localparam logic [STEP_BITS-1:0] STEP_START  = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_BYPASS = 3'd7;

   // microprogram rom
   function automatic ctrl_word_type program_word(input logic [STEP_BITS-1:0] pc);
      ctrl_word_type w;
      w           = '0;
      w.coef      = COEF_B0;
      w.op        = OP_NONE;
      w.src       = SRC_ZERO;
      w.target    = STEP_BYPASS;
      case (pc)
         3'd0: begin
            // x*b0, leave for the pass path when bypassed
            w.mul_en    = 1'b1;
            w.coef      = COEF_B0;
            w.op        = OP_CLEAR;
            w.br_bypass = 1'b1;
         end
         3'd1: begin
            // yacc = b0*x + d1, start x*b1
            w.op     = OP_LOAD;
            w.src    = SRC_D1;
            w.mul_en = 1'b1;
            w.coef   = COEF_B1;
         end
         3'd2: begin
            // output sample from yacc
            w.op = OP_ROUND;
         end
         3'd3: begin
            // z1 = b1*x + d2, start y*a1
            w.op     = OP_LOAD;
            w.src    = SRC_D2;
            w.mul_en = 1'b1;
            w.mul_y  = 1'b1;
            w.coef   = COEF_A1;
         end
         3'd4: begin
            // z1 -= a1*y into d1, start x*b2
            w.op     = OP_SUB;
            w.wr_d1  = 1'b1;
            w.mul_en = 1'b1;
            w.coef   = COEF_B2;
         end
         3'd5: begin
            // z2 = b2*x, start y*a2
            w.op     = OP_LOAD;
            w.src    = SRC_ZERO;
            w.mul_en = 1'b1;
            w.mul_y  = 1'b1;
            w.coef   = COEF_A2;
         end
         3'd6: begin
            // z2 -= a2*y into d2, deliver
            w.op    = OP_SUB;
            w.wr_d2 = 1'b1;
            w.last  = 1'b1;
         end
         3'd7: begin
            // bypass: pass the sample, deliver
            w.op   = OP_PASS;
            w.last = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/bqf_datapath.sv
// biquad datapath: shared multiplier, saturating accumulator, rounding unit, delay registers
module bqf_datapath #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_BITS      = 24,
   parameter int COEF_FRAC_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bqf_pkg::ctrl_word_type        ctrl,
   input  logic                          exec,
   input  logic                          load_x,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [COEF_BITS-1:0]   ff_gain_0,
   input  logic signed [COEF_BITS-1:0]   ff_gain_1,
   input  logic signed [COEF_BITS-1:0]   ff_gain_2,
   input  logic signed [COEF_BITS-1:0]   fb_gain_1,
   input  logic signed [COEF_BITS-1:0]   fb_gain_2,
   output logic signed [SAMPLE_BITS-1:0] y_in,
   output logic                          clip_in
);

   localparam int ACC_BITS   = bqf_pkg::ACC_BITS;
   localparam int ACC_GUARD  = bqf_pkg::ACC_GUARD;
   localparam int PW         = SAMPLE_BITS + COEF_BITS;
   localparam int TW         = PW + 1;
   localparam int SW         = ((TW > ACC_BITS) ? TW : ACC_BITS) + 1;
   localparam int RW         = ACC_BITS + 1;
   localparam int RSW        = RW - ACC_GUARD;
   localparam int PROD_SHIFT = COEF_FRAC_BITS - ACC_GUARD;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [SAMPLE_BITS-1:0] x_in;
   logic signed [SAMPLE_BITS-1:0] y_ff;
   logic signed [PW-1:0]          prod_ff;
   logic signed [PW-1:0]          prod_in;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic signed [ACC_BITS-1:0]    acc_in;
   logic signed [ACC_BITS-1:0]    d1_ff;
   logic signed [ACC_BITS-1:0]    d1_in;
   logic signed [ACC_BITS-1:0]    d2_ff;
   logic signed [ACC_BITS-1:0]    d2_in;
   logic                          clip_ff;

   logic signed [SAMPLE_BITS-1:0] mul_a;
   logic signed [COEF_BITS-1:0]   mul_c;
   logic signed [TW-1:0]          prod_w;
   logic signed [TW-1:0]          term;
   logic signed [ACC_BITS-1:0]    addend;
   logic signed [SW-1:0]          sum;
   logic [SW-ACC_BITS:0]          sum_top;
   logic                          alu_ovf;
   logic signed [ACC_BITS-1:0]    alu_res;
   logic signed [RW-1:0]          rsum;
   logic signed [RSW-1:0]         rsh;
   logic [RSW-SAMPLE_BITS:0]      rsh_top;
   logic                          rnd_ovf;
   logic signed [SAMPLE_BITS-1:0] rnd_res;

   // multiplier operand selection
   assign mul_a = ctrl.mul_y ? y_ff : x_ff;

   always_comb begin
      case (ctrl.coef)
         bqf_pkg::COEF_B0: mul_c = ff_gain_0;
         bqf_pkg::COEF_B1: mul_c = ff_gain_1;
         bqf_pkg::COEF_B2: mul_c = ff_gain_2;
         bqf_pkg::COEF_A1: mul_c = fb_gain_1;
         bqf_pkg::COEF_A2: mul_c = fb_gain_2;
         default:          mul_c = ff_gain_0;
      endcase
   end

   assign prod_in = mul_a * mul_c;

   // product to accumulator scale, round half up
   assign prod_w = TW'(prod_ff);

   generate
      if (PROD_SHIFT > 0) begin : g_round
         logic signed [TW-1:0] prod_rnd;
         assign prod_rnd = prod_w + (TW'(1) <<< (PROD_SHIFT - 1));
         assign term     = prod_rnd >>> PROD_SHIFT;
      end else begin : g_exact
         assign term = prod_w;
      end
   endgenerate

   // saturating add / subtract
   always_comb begin
      case (ctrl.src)
         bqf_pkg::SRC_D1:   addend = d1_ff;
         bqf_pkg::SRC_D2:   addend = d2_ff;
         bqf_pkg::SRC_ZERO: addend = '0;
         default:           addend = '0;
      endcase
      if (ctrl.op == bqf_pkg::OP_SUB) begin
         sum = SW'(acc_ff) - SW'(term);
      end else begin
         sum = SW'(addend) + SW'(term);
      end
   end

   assign sum_top = sum[SW-1:ACC_BITS-1];
   assign alu_ovf = !((&sum_top) || !(|sum_top));
   assign alu_res = alu_ovf ? (sum[SW-1] ? ACC_MIN : ACC_MAX) : sum[ACC_BITS-1:0];

   // output rounding and saturation
   assign rsum    = RW'(acc_ff) + (RW'(1) <<< (ACC_GUARD - 1));
   assign rsh     = rsum[RW-1:ACC_GUARD];
   assign rsh_top = rsh[RSW-1:SAMPLE_BITS-1];
   assign rnd_ovf = !((&rsh_top) || !(|rsh_top));
   assign rnd_res = rnd_ovf ? (rsh[RSW-1] ? SMP_MIN : SMP_MAX) : rsh[SAMPLE_BITS-1:0];

   // next values per control word
   always_comb begin
      x_in    = load_x ? sample : x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      d1_in   = d1_ff;
      d2_in   = d2_ff;
      clip_in = clip_ff;
      if (exec) begin
         case (ctrl.op)
            bqf_pkg::OP_CLEAR: begin
               clip_in = 1'b0;
            end
            bqf_pkg::OP_LOAD, bqf_pkg::OP_SUB: begin
               acc_in  = alu_res;
               clip_in = clip_ff | alu_ovf;
            end
            bqf_pkg::OP_ROUND: begin
               y_in    = rnd_res;
               clip_in = clip_ff | rnd_ovf;
            end
            bqf_pkg::OP_PASS: begin
               y_in    = x_ff;
               clip_in = 1'b0;
            end
            default: begin
            end
         endcase
         if (ctrl.wr_d1) begin
            d1_in = alu_res;
         end
         if (ctrl.wr_d2) begin
            d2_in = alu_res;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      if (exec && ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff   <= '0;
         d2_ff   <= '0;
         clip_ff <= 1'b0;
      end else begin
         d1_ff   <= d1_in;
         d2_ff   <= d2_in;
         clip_ff <= clip_in;
      end
   end

endmodule

FILE: rtl/biquad_iir_filter.sv
// biquad iir filter top: register port, microcode sequencer, result register
// rsp_valid is registered when the last microcode step executes: step 6 filtering, step 7 bypassed
// each filtered sample runs seven microcode steps (two when bypassed) on one multiplier;
//   a new sample is stalled until the last step of the current sample has executed
// the next sample is taken while the previous result still waits in the output register
// reset: synchronous; coefficients return to unity gain, bypass on, delay state cleared
module biquad_iir_filter #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_BITS      = 24,
   parameter int COEF_FRAC_BITS = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input samples
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   // results
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic                                   rsp_clipped,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [bqf_pkg::CSR_ADDR_BITS-1:0]      paddr,
   input  logic [bqf_pkg::CSR_DATA_BITS-1:0]      pwdata,
   output logic [bqf_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                   pready
);

   localparam int DW = bqf_pkg::CSR_DATA_BITS;
   localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) <<< COEF_FRAC_BITS;

   logic signed [COEF_BITS-1:0]   ff_gain_0_ff;
   logic signed [COEF_BITS-1:0]   ff_gain_1_ff;
   logic signed [COEF_BITS-1:0]   ff_gain_2_ff;
   logic signed [COEF_BITS-1:0]   fb_gain_1_ff;
   logic signed [COEF_BITS-1:0]   fb_gain_2_ff;
   logic                          bypass_ff;

   logic                                 busy_ff;
   logic [bqf_pkg::STEP_BITS-1:0]        pc_ff;
   logic                                 rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]        rsp_sample_ff;
   logic                                 rsp_clip_ff;

   bqf_pkg::ctrl_word_type        word;
   bqf_pkg::reg_idx_type          reg_idx;
   logic                          csr_wr;
   logic                          accept;
   logic                          exec;
   logic signed [SAMPLE_BITS-1:0] y_next;
   logic                          clip_next;

   // register access decode
   assign reg_idx = bqf_pkg::reg_idx_type'(paddr[bqf_pkg::CSR_ADDR_BITS-1:2]);
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_gain_0_ff <= COEF_ONE;
         ff_gain_1_ff <= '0;
         ff_gain_2_ff <= '0;
         fb_gain_1_ff <= '0;
         fb_gain_2_ff <= '0;
         bypass_ff    <= 1'b1;
      end else if (csr_wr) begin
         case (reg_idx)
            bqf_pkg::REG_FF_GAIN_0: ff_gain_0_ff <= pwdata[COEF_BITS-1:0];
            bqf_pkg::REG_FF_GAIN_1: ff_gain_1_ff <= pwdata[COEF_BITS-1:0];
            bqf_pkg::REG_FF_GAIN_2: ff_gain_2_ff <= pwdata[COEF_BITS-1:0];
            bqf_pkg::REG_FB_GAIN_1: fb_gain_1_ff <= pwdata[COEF_BITS-1:0];
            bqf_pkg::REG_FB_GAIN_2: fb_gain_2_ff <= pwdata[COEF_BITS-1:0];
            bqf_pkg::REG_BYPASS:    bypass_ff    <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (reg_idx)
         bqf_pkg::REG_FF_GAIN_0: prdata = DW'(ff_gain_0_ff);
         bqf_pkg::REG_FF_GAIN_1: prdata = DW'(ff_gain_1_ff);
         bqf_pkg::REG_FF_GAIN_2: prdata = DW'(ff_gain_2_ff);
         bqf_pkg::REG_FB_GAIN_1: prdata = DW'(fb_gain_1_ff);
         bqf_pkg::REG_FB_GAIN_2: prdata = DW'(fb_gain_2_ff);
         bqf_pkg::REG_BYPASS:    prdata = {{(DW-1){1'b0}}, bypass_ff};
         default:                prdata = '0;
      endcase
   end

   // microcode fetch and step control
   assign word      = bqf_pkg::program_word(pc_ff);
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   // the delivering step waits while the result register is still held
   assign exec      = busy_ff && !(word.last && rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= bqf_pkg::STEP_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         // sequencer
         if (accept) begin
            busy_ff <= 1'b1;
            pc_ff   <= bqf_pkg::STEP_START;
         end else if (exec) begin
            if (word.last) begin
               busy_ff <= 1'b0;
            end else if (word.br_bypass && bypass_ff) begin
               pc_ff <= word.target;
            end else begin
               pc_ff <= pc_ff + 1'b1;
            end
         end
         // result beat
         if (exec && word.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (exec && word.last) begin
         rsp_sample_ff <= y_next;
         rsp_clip_ff   <= clip_next;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;

   bqf_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_BITS      (COEF_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (word),
      .exec      (exec),
      .load_x    (accept),
      .sample    (req_sample_in),
      .ff_gain_0 (ff_gain_0_ff),
      .ff_gain_1 (ff_gain_1_ff),
      .ff_gain_2 (ff_gain_2_ff),
      .fb_gain_1 (fb_gain_1_ff),
      .fb_gain_2 (fb_gain_2_ff),
      .y_in      (y_next),
      .clip_in   (clip_next)
   );

endmodule

FILE: tb/sv/tb_biquad_iir_filter.sv
// testbench for the biquad iir filter: register setups, sample stream, result scoreboard
`timescale 1ns / 100ps

module tb_biquad_iir_filter;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_BITS      = 24;
   localparam int COEF_FRAC_BITS = 20;
   localparam int PROD_SHIFT     = COEF_FRAC_BITS - bqf_pkg::ACC_GUARD;

   localparam longint ACC_MAX    = (64'sd1 <<< (bqf_pkg::ACC_BITS - 1)) - 1;
   localparam longint ACC_MIN    = -ACC_MAX - 1;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   localparam int COEF_MAX = 8388607;
   localparam int COEF_MIN = -8388608;
   localparam int COEF_ONE = 1 << COEF_FRAC_BITS;

   // addresses past the register file, writes there must do nothing
   localparam logic [bqf_pkg::REG_IDX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [bqf_pkg::REG_IDX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

   localparam int PHASES         = 14;
   localparam int PHASE_SAMPLES  = 118;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_CYCLES    = 300;

   typedef enum {MIX_STABLE, MIX_WILD, MIX_EDGE, MIX_BYPASS} coef_mix_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          clipped;
   } filter_out_type;

   // filter state tracker and queue of expected output samples
   class filter_scoreboard;
      logic signed [COEF_BITS-1:0] b0, b1, b2, a1, a2;
      logic                        bypass_on;
      longint                      d1, d2;
      bit                          clip_flag;
      filter_out_type              expected_q[$];
      int                          mismatch_count;

      function new();
         b0 = COEF_ONE;
         b1 = '0;
         b2 = '0;
         a1 = '0;
         a2 = '0;
         bypass_on = 1'b1;
         d1 = 0;
         d2 = 0;
         mismatch_count = 0;
      endfunction

      function void set_reg(logic [bqf_pkg::REG_IDX_BITS-1:0] idx,
                            logic [bqf_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            bqf_pkg::REG_FF_GAIN_0: b0 = value[COEF_BITS-1:0];
            bqf_pkg::REG_FF_GAIN_1: b1 = value[COEF_BITS-1:0];
            bqf_pkg::REG_FF_GAIN_2: b2 = value[COEF_BITS-1:0];
            bqf_pkg::REG_FB_GAIN_1: a1 = value[COEF_BITS-1:0];
            bqf_pkg::REG_FB_GAIN_2: a2 = value[COEF_BITS-1:0];
            bqf_pkg::REG_BYPASS:    bypass_on = value[0];
            default: ;
         endcase
      endfunction

      function longint round_half_up(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function longint scaled_product(longint v, longint c);
         return round_half_up(v * c, PROD_SHIFT);
      endfunction

      function longint sat_acc(longint v);
         if (v > ACC_MAX) begin
            clip_flag = 1'b1;
            return ACC_MAX;
         end
         if (v < ACC_MIN) begin
            clip_flag = 1'b1;
            return ACC_MIN;
         end
         return v;
      endfunction

      function longint sat_sample(longint v);
         if (v > SAMPLE_MAX) begin
            clip_flag = 1'b1;
            return SAMPLE_MAX;
         end
         if (v < SAMPLE_MIN) begin
            clip_flag = 1'b1;
            return SAMPLE_MIN;
         end
         return v;
      endfunction

      // one accepted input sample: run the filter and queue its output
      function void note_sample(logic signed [SAMPLE_BITS-1:0] x);
         filter_out_type e;
         longint         xl, yacc, y, z1, z2;
         xl = x;
         if (bypass_on) begin
            e.sample  = x;
            e.clipped = 1'b0;
         end else begin
            clip_flag = 1'b0;
            yacc = sat_acc(scaled_product(xl, b0) + d1);
            y    = sat_sample(round_half_up(yacc, bqf_pkg::ACC_GUARD));
            z1   = sat_acc(scaled_product(xl, b1) + d2);
            z1   = sat_acc(z1 - scaled_product(y, a1));
            z2   = sat_acc(scaled_product(xl, b2));
            z2   = sat_acc(z2 - scaled_product(y, a2));
            d1   = z1;
            d2   = z2;
            e.sample  = y[SAMPLE_BITS-1:0];
            e.clipped = clip_flag;
         end
         expected_q.push_back(e);
      endfunction

      // one accepted result beat against the oldest expected output
      function void check_output(logic signed [SAMPLE_BITS-1:0] sample, logic clipped);
         filter_out_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result sample_out %0d clipped %0b",
                     $time, sample, clipped);
            mismatch_count++;
            return;
         end
         e = expected_q.pop_front();
         if (sample !== e.sample) begin
            $display("%0t: sample_out expected %0d got %0d", $time, e.sample, sample);
            mismatch_count++;
         end
         if (clipped !== e.clipped) begin
            $display("%0t: clipped expected %0b got %0b", $time, e.clipped, clipped);
            mismatch_count++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [SAMPLE_BITS-1:0]        req_sample_in = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0]        rsp_sample_out;
   logic                                 rsp_clipped;
   logic                                 psel = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite = 1'b0;
   logic [bqf_pkg::CSR_ADDR_BITS-1:0]    paddr = '0;
   logic [bqf_pkg::CSR_DATA_BITS-1:0]    pwdata = '0;
   logic [bqf_pkg::CSR_DATA_BITS-1:0]    prdata;
   logic                                 pready;

   filter_scoreboard sb;
   int               result_beats = 0;

   biquad_iir_filter uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit: the worst case run ends far below it
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // result beat monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_output(rsp_sample_out, rsp_clipped);
         result_beats++;
      end
   end

   // result side pacing, with two long hold-offs to back up the input
   initial begin : rsp_pacer
      int next_hold;
      int pick;
      next_hold = 400;
      forever begin
         pick = $urandom_range(0, 99);
         if (result_beats >= next_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            next_hold = (next_hold < 1000) ? 1100 : 32'h7fffffff;
         end else if (pick < 5) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(100, 300)) @(posedge clock);
         end else if (pick < 70) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (pick < 95) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(8, 30)) @(posedge clock);
         end
      end
   end

   // register write: setup cycle, access cycle until pready, then back to idle
   task automatic write_reg(input logic [bqf_pkg::REG_IDX_BITS-1:0] idx,
                            input logic [bqf_pkg::CSR_DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   // full filter setup, junk in the unused upper bits of each write
   task automatic program_filter(input int g0, input int g1, input int g2,
                                 input int f1, input int f2, input bit bypass_bit);
      logic [bqf_pkg::CSR_DATA_BITS-1:0] junk;
      junk = $urandom();
      write_reg(bqf_pkg::REG_FF_GAIN_0, {junk[31:24], g0[23:0]});
      junk = $urandom();
      write_reg(bqf_pkg::REG_FF_GAIN_1, {junk[31:24], g1[23:0]});
      junk = $urandom();
      write_reg(bqf_pkg::REG_FF_GAIN_2, {junk[31:24], g2[23:0]});
      junk = $urandom();
      write_reg(bqf_pkg::REG_FB_GAIN_1, {junk[31:24], f1[23:0]});
      junk = $urandom();
      write_reg(bqf_pkg::REG_FB_GAIN_2, {junk[31:24], f2[23:0]});
      junk = $urandom();
      write_reg(bqf_pkg::REG_BYPASS, {junk[31:1], bypass_bit});
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] corner_sample(int k);
      case (k)
         0:       return SAMPLE_MAX[SAMPLE_BITS-1:0];
         1:       return SAMPLE_MIN[SAMPLE_BITS-1:0];
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_BITS'(1);
      endcase
   endfunction

   // half full scale, a third quiet signal, the rest corner values
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      logic [31:0] raw;
      int          pick;
      raw  = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 50) return raw[SAMPLE_BITS-1:0];
      if (pick < 85) return SAMPLE_BITS'($signed(raw[15:0]));
      return corner_sample($urandom_range(0, 4));
   endfunction

   function automatic int edge_coef();
      case ($urandom_range(0, 3))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2:       return 0;
         default: return COEF_ONE;
      endcase
   endfunction

   // one input beat, then a random gap unless the sender is running flat out
   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] x, input bit calm);
      int pick;
      int gap;
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall);
      sb.note_sample(x);
      pick = $urandom_range(0, 99);
      if (calm || pick < 60) gap = 0;
      else if (pick < 96) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending, let every expected sample come out, then settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // main sequence
   initial begin : stimulus
      coef_mix_type mix;
      int           g0, g1, g2, f1, f2, bound;
      bit           calm;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state is bypass: corners and alternating bit patterns
      for (int k = 0; k < 5; k++) push_sample(corner_sample(k), 1'b0);
      push_sample(24'sh555555, 1'b0);
      push_sample(24'shaaaaaa, 1'b0);
      wait_idle();

      // writes past the register file, then unity gain filtering
      write_reg(REG_UNMAPPED_LO, $urandom());
      write_reg(REG_UNMAPPED_HI, $urandom());
      program_filter(COEF_ONE, 0, 0, 0, 0, 1'b0);
      for (int k = 0; k < 5; k++) push_sample(corner_sample(k), 1'b0);
      wait_idle();

      // largest gain drives the output into saturation
      program_filter(COEF_MAX, 0, 0, 0, 0, 1'b0);
      push_sample(corner_sample(0), 1'b1);
      push_sample(corner_sample(1), 1'b1);
      wait_idle();

      // all coefficients at the negative extreme, runaway feedback
      program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
      for (int k = 0; k < 5; k++) push_sample(corner_sample(k), 1'b1);
      push_sample('0, 1'b1);
      wait_idle();

      // all coefficients at the positive extreme
      program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
      push_sample(corner_sample(0), 1'b0);
      push_sample(corner_sample(1), 1'b0);
      push_sample(corner_sample(0), 1'b0);
      push_sample(corner_sample(2), 1'b0);
      wait_idle();

      // random phases, each with its own coefficient setup
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) mix = MIX_WILD;
         else if (phase == 3 || phase == 9) mix = MIX_BYPASS;
         else if (phase == 6 || phase == PHASES - 1) mix = MIX_EDGE;
         else mix = ($urandom_range(0, 9) < 7) ? MIX_STABLE : MIX_WILD;

         case (mix)
            MIX_STABLE: begin
               // poles inside the unit circle, gains within +-1.0
               g0 = $urandom_range(0, 2 * COEF_ONE) - COEF_ONE;
               g1 = $urandom_range(0, 2 * COEF_ONE) - COEF_ONE;
               g2 = $urandom_range(0, 2 * COEF_ONE) - COEF_ONE;
               f2 = $urandom_range(0, 1887436) - 943718;
               bound = ((COEF_ONE + f2) / 20) * 19;
               f1 = $urandom_range(0, 2 * bound) - bound;
            end
            MIX_EDGE: begin
               g0 = edge_coef();
               g1 = edge_coef();
               g2 = edge_coef();
               f1 = edge_coef();
               f2 = edge_coef();
            end
            default: begin
               g0 = $urandom();
               g1 = $urandom();
               g2 = $urandom();
               f1 = $urandom();
               f2 = $urandom();
            end
         endcase
         program_filter(g0, g1, g2, f1, f2, mix == MIX_BYPASS);

         calm = (phase % 5 == 2);
         for (int n = 0; n < PHASE_SAMPLES; n++) push_sample(random_sample(), calm);
         wait_idle();
      end

      if (sb.mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
